// ----- design/fbceg_pkg.sv -----
// Shared types, constants and helper functions for the black-frame check and exposure gain block.
`timescale 1ns / 1ps
`default_nettype none

package fbceg_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int PIX_W       = 32;

  localparam int CNT_W       = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int POS_W       = $clog2(MAX_DIM * MAX_DIM);
  localparam int COUNT_MAX   = MAX_DIM * MAX_DIM;

  localparam int NUM_SAMPLES = 5;
  localparam int HITS_W      = $clog2(NUM_SAMPLES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CH_W        = 8;
  localparam int ADD_W       = 10;
  localparam int SUM_W       = 12;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam int CH8_MAX     = 255;
  localparam int CH5_MAX     = 31;
  localparam int CH6_MAX     = 63;

  localparam int BLACK_8     = 90;
  localparam int BLACK_5     = 11;
  localparam int BLACK_6     = 22;

  localparam logic [PIX_W-1:0] ALPHA_FULL = 32'hFF00_0000;

  localparam int GAIN_LIMIT     = 1500;
  localparam int GAIN_TOP       = 3000;
  localparam int GAIN_PRE_SHIFT = 2;
  localparam int GAIN_DIV       = GAIN_LIMIT >> GAIN_PRE_SHIFT;
  localparam int GAIN_SHIFT     = 26;
  localparam int GAIN_MUL       = ((1 << GAIN_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
  localparam int PROD_W         = CH_W + SUM_W;
  localparam int DIVQ_W         = PROD_W - GAIN_PRE_SHIFT;
  localparam int MUL_W          = $clog2(GAIN_MUL + 1);
  localparam int QUO_W          = PROD_W - $clog2(GAIN_LIMIT) + 1;

  localparam int SCALE_SHIFT = 20;
  localparam int SCALE5_MUL  = CH8_MAX * (((1 << SCALE_SHIFT) + CH5_MAX - 1) / CH5_MAX);
  localparam int SCALE6_MUL  = CH8_MAX * (((1 << SCALE_SHIFT) + CH6_MAX - 1) / CH6_MAX);

  localparam logic [CFG_DIM_W-1:0] RESET_WIDTH  = 13'd64;
  localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT = 13'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FORMAT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FMT_RGBA = 1'b0,
    FMT_565  = 1'b1
  } pix_fmt_t;

  typedef enum logic {
    KIND_ANALYZE = 1'b0,
    KIND_ADJUST  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] width;
    logic [CFG_DIM_W-1:0] height;
    pix_fmt_t             format;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic              start;
    logic [HITS_W-1:0] hits;
    logic [PIX_W-1:0]  pixel;
  } req_t;

  function automatic logic [CFG_DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
    logic [CFG_DIM_W-1:0] r;
    if (d == '0) begin
      r = CFG_DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = CFG_DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sample_pos(input logic [CFG_DIM_W-1:0] w,
                                                  input logic [CFG_DIM_W-1:0] h,
                                                  input int idx);
    logic [CFG_DIM_W-1:0]   wc;
    logic [CFG_DIM_W-1:0]   hc;
    logic [CFG_DIM_W-1:0]   row;
    logic [CFG_DIM_W-1:0]   col;
    logic [CFG_DIM_W-1:0]   h14;
    logic [CFG_DIM_W-1:0]   h34;
    logic [CFG_DIM_W-1:0]   w14;
    logic [CFG_DIM_W-1:0]   w34;
    logic [2*CFG_DIM_W-1:0] p;
    wc  = clamp_dim(w);
    hc  = clamp_dim(h);
    h14 = hc >> 2;
    w14 = wc >> 2;
    h34 = CFG_DIM_W'((32'(hc) * 3) >> 2);
    w34 = CFG_DIM_W'((32'(wc) * 3) >> 2);
    case (idx)
      0: begin
        row = hc >> 1;
        col = wc >> 1;
      end
      1: begin
        row = h14;
        col = w14;
      end
      2: begin
        row = h34;
        col = w34;
      end
      3: begin
        row = h14;
        col = w34;
      end
      default: begin
        row = h34;
        col = w14;
      end
    endcase
    p = (2*CFG_DIM_W)'(row) * (2*CFG_DIM_W)'(wc) + (2*CFG_DIM_W)'(col);
    return POS_W'(p);
  endfunction

  function automatic logic [CH_W-1:0] scale5(input logic [4:0] c);
    logic [31:0] p;
    p = 32'(c) * 32'(SCALE5_MUL);
    return CH_W'(p >> SCALE_SHIFT);
  endfunction

  function automatic logic [CH_W-1:0] scale6(input logic [5:0] c);
    logic [31:0] p;
    p = 32'(c) * 32'(SCALE6_MUL);
    return CH_W'(p >> SCALE_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ----- design/fbceg_front.sv -----
// Front end: accepts pixel requests, tracks the pass position and counts sample hits.
`timescale 1ns / 1ps
`default_nettype none

module fbceg_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fbceg_pkg::cfg_t              cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic                         in_first_pixel,
  input  wire logic [fbceg_pkg::PIX_W-1:0]  in_pixel_in,
  input  wire logic                         q_full,
  output logic                              q_push,
  output fbceg_pkg::req_t                   q_req
);

  logic [fbceg_pkg::CNT_W-1:0]  cnt_r;
  logic [fbceg_pkg::CNT_W-1:0]  cnt_nxt;
  logic [fbceg_pkg::CNT_W-1:0]  cur;
  logic [fbceg_pkg::POS_W-1:0]  pos_r   [fbceg_pkg::NUM_SAMPLES];
  logic [fbceg_pkg::POS_W-1:0]  fresh   [fbceg_pkg::NUM_SAMPLES];
  logic [fbceg_pkg::POS_W-1:0]  use_pos [fbceg_pkg::NUM_SAMPLES];
  logic                         start;
  logic [fbceg_pkg::HITS_W-1:0] hits;

  always_comb begin
    in_stall = q_full;
    q_push   = in_valid && !q_full;
    start    = in_first_pixel && (fbceg_pkg::kind_t'(in_kind) == fbceg_pkg::KIND_ANALYZE);
    cur      = in_first_pixel ? '0 : cnt_r;
    hits     = '0;
    for (int i = 0; i < fbceg_pkg::NUM_SAMPLES; i++) begin
      fresh[i]   = fbceg_pkg::sample_pos(cfg.width, cfg.height, i);
      use_pos[i] = start ? fresh[i] : pos_r[i];
      if (fbceg_pkg::CNT_W'(use_pos[i]) == cur) begin
        hits = hits + fbceg_pkg::HITS_W'(1);
      end
    end
    cnt_nxt = cnt_r;
    if (q_push) begin
      cnt_nxt = (cur < fbceg_pkg::CNT_W'(fbceg_pkg::COUNT_MAX)) ?
                cur + fbceg_pkg::CNT_W'(1) : cur;
    end
    q_req.kind  = fbceg_pkg::kind_t'(in_kind);
    q_req.start = start;
    q_req.hits  = hits;
    q_req.pixel = in_pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < fbceg_pkg::NUM_SAMPLES; i++) begin
        pos_r[i] <= fbceg_pkg::sample_pos(fbceg_pkg::RESET_WIDTH, fbceg_pkg::RESET_HEIGHT, i);
      end
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push && start) begin
        for (int i = 0; i < fbceg_pkg::NUM_SAMPLES; i++) begin
          pos_r[i] <= fresh[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fbceg_queue.sv -----
// Request queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module fbceg_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fbceg_pkg::req_t push_data,
  input  wire logic            pop,
  output logic                 head_valid,
  output fbceg_pkg::req_t      head,
  output logic                 full
);

  fbceg_pkg::req_t              mem_r [fbceg_pkg::QUEUE_DEPTH];
  logic [fbceg_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [fbceg_pkg::QPTR_W-1:0] wr_ptr_nxt;
  logic [fbceg_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [fbceg_pkg::QPTR_W-1:0] rd_ptr_nxt;
  logic [fbceg_pkg::QCNT_W-1:0] count_r;
  logic [fbceg_pkg::QCNT_W-1:0] count_nxt;
  logic                         do_push;
  logic                         do_pop;

  always_comb begin
    head_valid = count_r != '0;
    full       = count_r == fbceg_pkg::QCNT_W'(fbceg_pkg::QUEUE_DEPTH);
    head       = mem_r[rd_ptr_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fbceg_pkg::QPTR_W'(fbceg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + fbceg_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fbceg_pkg::QPTR_W'(fbceg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + fbceg_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + fbceg_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - fbceg_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/fbceg_back.sv -----
// Back end: updates brightness sum and black flag, applies the exposure gain in two stages.
`timescale 1ns / 1ps
`default_nettype none

module fbceg_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fbceg_pkg::cfg_t               cfg,
  input  wire logic                          q_valid,
  input  wire fbceg_pkg::req_t               q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fbceg_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                               out_is_black,
  output logic [fbceg_pkg::SUM_W-1:0]        out_sample_sum,
  output logic                               out_gain_active
);

  localparam int CH_W   = fbceg_pkg::CH_W;
  localparam int SUM_W  = fbceg_pkg::SUM_W;
  localparam int PROD_W = fbceg_pkg::PROD_W;
  localparam int DIVQ_W = fbceg_pkg::DIVQ_W;
  localparam int MUL_W  = fbceg_pkg::MUL_W;
  localparam int QUO_W  = fbceg_pkg::QUO_W;
  localparam int HIT_W  = fbceg_pkg::ADD_W + fbceg_pkg::HITS_W;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic             black_r;
  logic             black_nxt;

  logic                      a_valid_r;
  fbceg_pkg::kind_t          a_kind_r;
  logic                      a_active_r;
  logic [fbceg_pkg::PIX_W-1:0] a_pixel_r;
  logic [PROD_W-1:0]         a_prod_r [3];

  logic                        out_valid_r;
  logic [fbceg_pkg::PIX_W-1:0] out_pixel_r;
  logic                        out_black_r;
  logic [SUM_W-1:0]            out_sum_r;
  logic                        out_active_r;

  logic                      b_take;
  logic                      a_adv;
  logic [CH_W-1:0]           hc [3];
  logic [fbceg_pkg::ADD_W-1:0] add;
  logic                      bright;
  logic [SUM_W-1:0]          base_sum;
  logic                      base_black;
  logic [HIT_W-1:0]          hit_add;
  logic [HIT_W:0]            total;
  logic [SUM_W-1:0]          num;
  logic [PROD_W-1:0]         prod [3];

  logic [CH_W-1:0]           ac [3];
  logic [CH_W-1:0]           cmax [3];
  logic [DIVQ_W+MUL_W-1:0]   qfull [3];
  logic [QUO_W-1:0]          quo [3];
  logic [CH_W-1:0]           adj [3];
  logic [fbceg_pkg::PIX_W-1:0] res;

  always_comb begin
    b_take = !out_valid_r || !out_stall;
    a_adv  = !a_valid_r || b_take;
    q_pop  = q_valid && a_adv;

    if (cfg.format == fbceg_pkg::FMT_565) begin
      hc[0]  = CH_W'(q_head.pixel[15:11]);
      hc[1]  = CH_W'(q_head.pixel[10:5]);
      hc[2]  = CH_W'(q_head.pixel[4:0]);
      add    = fbceg_pkg::ADD_W'(fbceg_pkg::scale5(q_head.pixel[15:11]))
             + fbceg_pkg::ADD_W'(fbceg_pkg::scale6(q_head.pixel[10:5]))
             + fbceg_pkg::ADD_W'(fbceg_pkg::scale5(q_head.pixel[4:0]));
      bright = (hc[0] > CH_W'(fbceg_pkg::BLACK_5)) || (hc[1] > CH_W'(fbceg_pkg::BLACK_6))
            || (hc[2] > CH_W'(fbceg_pkg::BLACK_5));
    end else begin
      hc[0]  = q_head.pixel[7:0];
      hc[1]  = q_head.pixel[15:8];
      hc[2]  = q_head.pixel[23:16];
      add    = fbceg_pkg::ADD_W'(hc[0]) + fbceg_pkg::ADD_W'(hc[1]) + fbceg_pkg::ADD_W'(hc[2]);
      bright = (hc[0] > CH_W'(fbceg_pkg::BLACK_8)) || (hc[1] > CH_W'(fbceg_pkg::BLACK_8))
            || (hc[2] > CH_W'(fbceg_pkg::BLACK_8));
    end

    base_sum   = q_head.start ? '0 : sum_r;
    base_black = q_head.start ? 1'b1 : black_r;
    hit_add    = HIT_W'(q_head.hits) * HIT_W'(add);
    total      = (HIT_W + 1)'(base_sum) + (HIT_W + 1)'(hit_add);
    sum_nxt    = sum_r;
    black_nxt  = black_r;
    if (q_head.kind == fbceg_pkg::KIND_ANALYZE) begin
      sum_nxt   = (total > (HIT_W + 1)'(fbceg_pkg::SUM_MAX)) ? fbceg_pkg::SUM_MAX :
                  SUM_W'(total);
      black_nxt = base_black && !(bright && (q_head.hits != '0));
    end

    num = SUM_W'(fbceg_pkg::GAIN_TOP) - sum_r;
    for (int i = 0; i < 3; i++) begin
      prod[i] = PROD_W'(hc[i]) * PROD_W'(num);
    end
  end

  always_comb begin
    if (cfg.format == fbceg_pkg::FMT_565) begin
      ac[0]   = CH_W'(a_pixel_r[15:11]);
      ac[1]   = CH_W'(a_pixel_r[10:5]);
      ac[2]   = CH_W'(a_pixel_r[4:0]);
      cmax[0] = CH_W'(fbceg_pkg::CH5_MAX);
      cmax[1] = CH_W'(fbceg_pkg::CH6_MAX);
      cmax[2] = CH_W'(fbceg_pkg::CH5_MAX);
    end else begin
      ac[0]   = a_pixel_r[7:0];
      ac[1]   = a_pixel_r[15:8];
      ac[2]   = a_pixel_r[23:16];
      cmax[0] = CH_W'(fbceg_pkg::CH8_MAX);
      cmax[1] = CH_W'(fbceg_pkg::CH8_MAX);
      cmax[2] = CH_W'(fbceg_pkg::CH8_MAX);
    end
    for (int i = 0; i < 3; i++) begin
      qfull[i] = (DIVQ_W + MUL_W)'(a_prod_r[i] >> fbceg_pkg::GAIN_PRE_SHIFT)
               * (DIVQ_W + MUL_W)'(fbceg_pkg::GAIN_MUL);
      quo[i]   = QUO_W'(qfull[i] >> fbceg_pkg::GAIN_SHIFT);
      if (!a_active_r) begin
        adj[i] = ac[i];
      end else if (quo[i] > QUO_W'(cmax[i])) begin
        adj[i] = cmax[i];
      end else begin
        adj[i] = CH_W'(quo[i]);
      end
    end
    if (a_kind_r == fbceg_pkg::KIND_ANALYZE) begin
      res = a_pixel_r;
    end else if (cfg.format == fbceg_pkg::FMT_565) begin
      res = {16'b0, adj[0][4:0], adj[1][5:0], adj[2][4:0]};
    end else begin
      res = fbceg_pkg::ALPHA_FULL | {8'b0, adj[2], adj[1], adj[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      black_r     <= 1'b1;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        sum_r   <= sum_nxt;
        black_r <= black_nxt;
      end
      if (a_adv) begin
        a_valid_r <= q_valid;
      end
      if (b_take) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_kind_r   <= q_head.kind;
      a_pixel_r  <= q_head.pixel;
      a_active_r <= sum_r < SUM_W'(fbceg_pkg::GAIN_LIMIT);
      for (int i = 0; i < 3; i++) begin
        a_prod_r[i] <= prod[i];
      end
    end
    if (a_valid_r && b_take) begin
      out_pixel_r  <= res;
      out_black_r  <= black_r;
      out_sum_r    <= sum_r;
      out_active_r <= sum_r < SUM_W'(fbceg_pkg::GAIN_LIMIT);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pixel_r;
  assign out_is_black    = out_black_r;
  assign out_sample_sum  = out_sum_r;
  assign out_gain_active = out_active_r;

endmodule

`default_nettype wire

// ----- design/frame_black_check_exposure_gain.sv -----
// Top level of the black-frame check and exposure gain block.
`timescale 1ns / 1ps
`default_nettype none

// Each frame is streamed twice, one pixel request per cycle. Analyze pixels (kind 0) are echoed
// while five sample points update the running brightness sum and black flag; adjust pixels
// (kind 1) come back scaled by (3000 - sum) / 1500 when the sum is below 1500. The block takes
// one request per cycle while in_stall is low and passes each result from the four-entry request
// queue through the gain multiply stage and the reciprocal divide stage that drives the output
// register. in_stall rises only when the queue is full; the queue, the multiply stage and the
// output register hold up to six requests, so a stalled output holds the input side only once
// they are all taken. Register writes apply to the pixel format at once and to the sample points
// at the next analyze first pixel.
module frame_black_check_exposure_gain (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [fbceg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fbceg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic                              in_first_pixel,
  input  wire logic [fbceg_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [fbceg_pkg::PIX_W-1:0]            out_pixel_out,
  output logic                                   out_is_black,
  output logic [fbceg_pkg::SUM_W-1:0]            out_sample_sum,
  output logic                                   out_gain_active
);

  fbceg_pkg::cfg_t cfg_r;
  fbceg_pkg::cfg_t cfg_nxt;
  fbceg_pkg::req_t push_req;
  fbceg_pkg::req_t head_req;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  logic            q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (fbceg_pkg::cfg_reg_t'(cfg_index))
        fbceg_pkg::REG_WIDTH:  cfg_nxt.width  = cfg_data[fbceg_pkg::CFG_DIM_W-1:0];
        fbceg_pkg::REG_HEIGHT: cfg_nxt.height = cfg_data[fbceg_pkg::CFG_DIM_W-1:0];
        fbceg_pkg::REG_FORMAT: cfg_nxt.format = fbceg_pkg::pix_fmt_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= fbceg_pkg::RESET_WIDTH;
      cfg_r.height <= fbceg_pkg::RESET_HEIGHT;
      cfg_r.format <= fbceg_pkg::FMT_RGBA;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fbceg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_first_pixel (in_first_pixel),
    .in_pixel_in    (in_pixel_in),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_req          (push_req)
  );

  fbceg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_req),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head_req),
    .full       (q_full)
  );

  fbceg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_head          (head_req),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_is_black    (out_is_black),
    .out_sample_sum  (out_sample_sum),
    .out_gain_active (out_gain_active)
  );

endmodule

`default_nettype wire

// ----- design/fbceg_checker.sv -----
// Port-level checker for the black-frame check and exposure gain block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module fbceg_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [fbceg_pkg::PIX_W-1:0]      out_pixel_out,
  input wire logic                             out_is_black,
  input wire logic [fbceg_pkg::SUM_W-1:0]      out_sample_sum,
  input wire logic                             out_gain_active
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_pixel_out, out_is_black, out_sample_sum, out_gain_active}))
    else $error("stalled result changed or dropped");

  a_gain_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_active ==
      (out_sample_sum < fbceg_pkg::SUM_W'(fbceg_pkg::GAIN_LIMIT)))
    else $error("gain flag disagrees with sample sum");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall raised without a prior request");

endmodule

bind frame_black_check_exposure_gain fbceg_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/fbceg_pixel_checker.sv -----
// Checker for the black-frame block: predicts each pixel result and compares it on arrival.
`timescale 1ns / 1ps

module fbceg_pixel_checker
  import fbceg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_kind,
  input  logic                  in_first_pixel,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PIX_W-1:0]      out_pixel_out,
  input  logic                  out_is_black,
  input  logic [SUM_W-1:0]      out_sample_sum,
  input  logic                  out_gain_active,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             black;
    logic [SUM_W-1:0] sum;
    logic             gain;
  } pix_result_t;

  pix_result_t          expected_pixels[$];
  logic [CFG_DIM_W-1:0] width_reg;
  logic [CFG_DIM_W-1:0] height_reg;
  pix_fmt_t             fmt_reg;
  int unsigned          pos_count;
  int unsigned          bright_sum;
  logic                 black_flag;
  int unsigned          spot[NUM_SAMPLES];
  int                   mismatches = 0;

  function automatic int unsigned bound_dim(logic [CFG_DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  task automatic locate_spots();
    int unsigned w;
    int unsigned h;
    w = bound_dim(width_reg);
    h = bound_dim(height_reg);
    spot[0] = (h / 2) * w + w / 2;
    spot[1] = (h / 4) * w + w / 4;
    spot[2] = (3 * h / 4) * w + 3 * w / 4;
    spot[3] = (h / 4) * w + 3 * w / 4;
    spot[4] = (3 * h / 4) * w + w / 4;
  endtask

  function automatic int unsigned gained(int unsigned c, int unsigned num, int unsigned cmax);
    int unsigned v;
    v = c * num / GAIN_LIMIT;
    return (v > cmax) ? cmax : v;
  endfunction

  task automatic add_sample(logic [PIX_W-1:0] px);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    int unsigned add;
    logic        bright;
    if (fmt_reg == FMT_RGBA) begin
      r = px[7:0];
      g = px[15:8];
      b = px[23:16];
      add = r + g + b;
      bright = (r > BLACK_8) || (g > BLACK_8) || (b > BLACK_8);
    end else begin
      r = px[15:11];
      g = px[10:5];
      b = px[4:0];
      add = r * CH8_MAX / CH5_MAX + g * CH8_MAX / CH6_MAX + b * CH8_MAX / CH5_MAX;
      bright = (r > BLACK_5) || (g > BLACK_6) || (b > BLACK_5);
    end
    bright_sum = bright_sum + add;
    if (bright_sum > SUM_MAX) bright_sum = SUM_MAX;
    if (bright) black_flag = 1'b0;
  endtask

  task automatic step_pixel(input kind_t kind, input logic first, input logic [PIX_W-1:0] px,
                            output pix_result_t res);
    int unsigned num;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    logic        active;
    if (first) begin
      pos_count = 0;
      if (kind == KIND_ANALYZE) begin
        bright_sum = 0;
        black_flag = 1'b1;
        locate_spots();
      end
    end
    if (kind == KIND_ANALYZE) begin
      for (int i = 0; i < NUM_SAMPLES; i++) begin
        if (spot[i] == pos_count) add_sample(px);
      end
      res.pixel = px;
    end else begin
      num = GAIN_TOP - bright_sum;
      active = bright_sum < GAIN_LIMIT;
      if (fmt_reg == FMT_RGBA) begin
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        if (active) begin
          r = gained(r, num, CH8_MAX);
          g = gained(g, num, CH8_MAX);
          b = gained(b, num, CH8_MAX);
        end
        res.pixel = ALPHA_FULL | {8'h00, b[7:0], g[7:0], r[7:0]};
      end else begin
        r = px[15:11];
        g = px[10:5];
        b = px[4:0];
        if (active) begin
          r = gained(r, num, CH5_MAX);
          g = gained(g, num, CH6_MAX);
          b = gained(b, num, CH5_MAX);
        end
        res.pixel = {16'h0000, r[4:0], g[5:0], b[4:0]};
      end
    end
    if (pos_count < COUNT_MAX) pos_count++;
    res.black = black_flag;
    res.sum   = bright_sum[SUM_W-1:0];
    res.gain  = bright_sum < GAIN_LIMIT;
  endtask

  always @(posedge clk) begin
    pix_result_t want;
    pix_result_t got;
    if (!rst_n) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      fmt_reg    = FMT_RGBA;
      pos_count  = 0;
      bright_sum = 0;
      black_flag = 1'b1;
      locate_spots();
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH: begin
            width_reg = cfg_data[CFG_DIM_W-1:0];
          end
          REG_HEIGHT: begin
            height_reg = cfg_data[CFG_DIM_W-1:0];
          end
          REG_FORMAT: begin
            fmt_reg = pix_fmt_t'(cfg_data[0]);
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        got.pixel = out_pixel_out;
        got.black = out_is_black;
        got.sum   = out_sample_sum;
        got.gain  = out_gain_active;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: pixel %h black %0d sum %0d gain %0d",
                     $realtime, got.pixel, got.black, got.sum, got.gain);
        end else begin
          want = expected_pixels.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                       $realtime, want.pixel, want.black, want.sum, want.gain,
                       got.pixel, got.black, got.sum, got.gain);
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_pixel(kind_t'(in_kind), in_first_pixel, in_pixel_in, want);
        expected_pixels.push_back(want);
      end
    end
    pending    <= expected_pixels.size();
    fail_count <= mismatches;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: clock, reset, frame and register stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import fbceg_pkg::*;

  localparam int TARGET_ITEMS = 1050;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 300;
  localparam int NO_CAP       = 1 << 30;

  typedef enum int {
    TONE_ANY,
    TONE_DARK,
    TONE_BLACK,
    TONE_EDGE
  } tone_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = KIND_ANALYZE;
  logic                  in_first_pixel = 1'b0;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_is_black;
  logic [SUM_W-1:0]      out_sample_sum;
  logic                  out_gain_active;

  int       fail_count;
  int       pending;
  pix_fmt_t fmt_now = FMT_RGBA;
  int       items_sent = 0;
  logic     steady = 1'b0;
  int       hold_token = 0;
  int       quiet_cycles = 0;

  always #5 clk = ~clk;

  frame_black_check_exposure_gain dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_first_pixel  (in_first_pixel),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_is_black    (out_is_black),
    .out_sample_sum  (out_sample_sum),
    .out_gain_active (out_gain_active)
  );

  fbceg_pixel_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_first_pixel  (in_first_pixel),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_is_black    (out_is_black),
    .out_sample_sum  (out_sample_sum),
    .out_gain_active (out_gain_active),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("frame_black_check_exposure_gain verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int   hold_left;
    int   hold_seen;
    logic calm;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      calm = steady;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 38);
      end
    end
  end

  task automatic rest(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_pixel(kind_t kind, logic first, logic [PIX_W-1:0] px);
    int gaps;
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_first_pixel <= first;
    in_pixel_in    <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
    gaps = 0;
    if (!steady) begin
      while ($urandom_range(99) < 38) gaps++;
    end
    if (gaps > 0) rest(gaps);
  endtask

  task automatic configure(int w, int h, pix_fmt_t fmt);
    rest(1);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_index <= REG_FORMAT;
    cfg_data  <= CFG_DATA_W'(fmt);
    @(negedge clk);
    cfg_we    <= 1'b0;
    fmt_now = fmt;
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(pix_fmt_t fmt, tone_t tone);
    logic [PIX_W-1:0] px;
    int unsigned      r;
    int unsigned      g;
    int unsigned      b;
    px = $urandom;
    if (tone == TONE_ANY) return px;
    if (tone == TONE_EDGE) begin
      r = $urandom_range(1);
      g = $urandom_range(1);
      b = $urandom_range(1);
      if (fmt == FMT_RGBA) begin
        r = r + BLACK_8;
        g = g + BLACK_8;
        b = b + BLACK_8;
      end else begin
        r = r + BLACK_5;
        g = g + BLACK_6;
        b = b + BLACK_5;
      end
    end else if (fmt == FMT_RGBA) begin
      r = $urandom_range(tone == TONE_DARK ? 110 : BLACK_8);
      g = $urandom_range(tone == TONE_DARK ? 110 : BLACK_8);
      b = $urandom_range(tone == TONE_DARK ? 110 : BLACK_8);
    end else begin
      r = $urandom_range(tone == TONE_DARK ? 14 : BLACK_5);
      g = $urandom_range(tone == TONE_DARK ? 28 : BLACK_6);
      b = $urandom_range(tone == TONE_DARK ? 14 : BLACK_5);
    end
    if (fmt == FMT_RGBA) begin
      px[7:0]   = r[7:0];
      px[15:8]  = g[7:0];
      px[23:16] = b[7:0];
    end else begin
      px[15:0] = {r[4:0], g[5:0], b[4:0]};
    end
    return px;
  endfunction

  task automatic stream_frame(int w, int h, int cap, tone_t tone);
    int unsigned cw;
    int unsigned ch;
    int unsigned span;
    int unsigned cut;
    cw = (w == 0) ? 1 : ((w > MAX_DIM) ? MAX_DIM : w);
    ch = (h == 0) ? 1 : ((h > MAX_DIM) ? MAX_DIM : h);
    span = cw * ch;
    if (span > cap) span = cap;
    cut = ($urandom_range(9) == 0) ? $urandom_range(span, 1) : span;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(19) == 0)
        send_pixel(kind_t'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      send_pixel(KIND_ANALYZE, i == 0, make_pixel(fmt_now, tone));
    end
    cut = ($urandom_range(9) == 0) ? $urandom_range(span, 1) : span;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(19) == 0)
        send_pixel(kind_t'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      send_pixel(KIND_ADJUST, i == 0, $urandom_range(3) == 0 ? make_pixel(fmt_now, TONE_DARK)
                                                             : $urandom);
    end
  endtask

  initial begin : stimulus
    int       w;
    int       h;
    int       cap;
    int       phase;
    tone_t    tone;
    pix_fmt_t fmt;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry; stop before the first sample point
    steady = 1'b1;
    stream_frame(64, 64, 40, TONE_ANY);
    steady = 1'b0;

    configure(2, 2, FMT_RGBA);
    hold_token++;
    send_pixel(KIND_ANALYZE, 1'b1, 32'h0000_0000);
    send_pixel(KIND_ANALYZE, 1'b0, 32'hFF5A_5A5A);
    send_pixel(KIND_ANALYZE, 1'b0, 32'h0001_0203);
    send_pixel(KIND_ANALYZE, 1'b0, 32'h0000_0A0A);
    send_pixel(KIND_ADJUST,  1'b1, 32'hFFFF_FFFF);
    send_pixel(KIND_ADJUST,  1'b0, 32'h0000_0000);
    send_pixel(KIND_ADJUST,  1'b0, 32'h0080_8080);
    send_pixel(KIND_ADJUST,  1'b0, 32'h1234_5678);
    send_pixel(KIND_ANALYZE, 1'b1, 32'h0000_005B);
    send_pixel(KIND_ADJUST,  1'b1, 32'h00FF_FFFF);

    configure(2, 2, FMT_565);
    send_pixel(KIND_ANALYZE, 1'b1, 32'hFFFF_0000);
    send_pixel(KIND_ANALYZE, 1'b0, 32'h0000_5ACB);
    send_pixel(KIND_ANALYZE, 1'b0, 32'h0000_FFFF);
    send_pixel(KIND_ANALYZE, 1'b0, 32'h0000_6000);
    send_pixel(KIND_ADJUST,  1'b1, 32'h0000_FFFF);
    send_pixel(KIND_ADJUST,  1'b0, 32'hFFFF_FFFF);
    send_pixel(KIND_ADJUST,  1'b0, 32'h0000_0841);

    configure(0, 0, FMT_565);
    stream_frame(0, 0, NO_CAP, TONE_DARK);
    configure(8191, 8191, FMT_RGBA);
    stream_frame(8191, 8191, 40, TONE_ANY);
    configure(4096, 1, FMT_565);
    stream_frame(4096, 1, 40, TONE_BLACK);
    configure(1, 4096, FMT_RGBA);
    stream_frame(1, 4096, 40, TONE_DARK);
    configure(4097, 2, FMT_565);
    stream_frame(4097, 2, 40, TONE_ANY);
    configure(1, 1, FMT_RGBA);
    stream_frame(1, 1, NO_CAP, TONE_EDGE);
    configure(3, 1, FMT_565);
    stream_frame(3, 1, NO_CAP, TONE_EDGE);

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case ($urandom_range(19))
        0: w = 0;
        1: w = $urandom_range(8191, 4090);
        default: w = $urandom_range(8, 1);
      endcase
      case ($urandom_range(19))
        0: h = 0;
        1: h = $urandom_range(8191, 4090);
        default: h = $urandom_range(8, 1);
      endcase
      cap = (w > 16 || h > 16) ? 48 : NO_CAP;
      fmt = pix_fmt_t'($urandom_range(1));
      configure(w, h, fmt);
      steady = (phase == 2);
      if (phase == 4) hold_token++;
      repeat ($urandom_range(3, 1)) begin
        tone = tone_t'($urandom_range(3));
        stream_frame(w, h, cap, tone);
      end
      phase++;
    end
    steady = 1'b0;

    rest(1);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("frame_black_check_exposure_gain verification clean");
    end else begin
      $display("frame_black_check_exposure_gain verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/fbceg_pkg.sv
design/fbceg_front.sv
design/fbceg_queue.sv
design/fbceg_back.sv
design/frame_black_check_exposure_gain.sv
design/fbceg_checker.sv
tb/sv/fbceg_pixel_checker.sv
tb/sv/tb_top.sv
